### rtl/zdls_pkg.sv
`timescale 1ns / 1ps

package zdls_pkg;

  localparam int OFFSET_BITS = 20;
  localparam int PRICE_BITS  = 32;
  localparam int THR_BITS    = 16;
  localparam int CHG_BITS    = 16;
  localparam int CNT_BITS    = $clog2(CHG_BITS);

  localparam logic [THR_BITS-1:0] THR_RESET   = THR_BITS'(3277);
  localparam logic [CHG_BITS-1:0] CHG_POS_MAX = {1'b0, {(CHG_BITS-1){1'b1}}};
  localparam logic [CHG_BITS-1:0] CHG_NEG_MAG = {1'b1, {(CHG_BITS-1){1'b0}}};

  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic                  is_first;
    logic                  is_last;
  } zdls_in_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0]     leg_start_index;
    logic [OFFSET_BITS-1:0]     leg_end_index;
    logic [PRICE_BITS-1:0]      leg_start_price;
    logic [PRICE_BITS-1:0]      leg_end_price;
    logic signed [CHG_BITS-1:0] leg_change;
    logic                       is_final;
  } zdls_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_EVAL,
    ST_DIV
  } zdls_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } zdls_div_stat_t;

endpackage

### rtl/zdls_div.sv
`timescale 1ns / 1ps

// shift-subtract divider, one quotient bit per cycle, saturated Q1.15 result
module zdls_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [zdls_pkg::PRICE_BITS-1:0]      start_price,
  input  logic [zdls_pkg::PRICE_BITS-1:0]      end_price,
  output zdls_pkg::zdls_div_stat_t             stat,
  output logic signed [zdls_pkg::CHG_BITS-1:0] change
);

  localparam int PB = zdls_pkg::PRICE_BITS;
  localparam int CB = zdls_pkg::CHG_BITS;

  logic                            busy;
  logic                            done;
  logic [zdls_pkg::CNT_BITS-1:0]   cnt;
  logic [PB-1:0]                   rem;
  logic [PB-1:0]                   dvsr;
  logic [CB-1:0]                   quo;
  logic                            feed;
  logic                            neg;
  logic                            sat;
  logic                            zero;

  logic [PB-1:0] mag;
  logic [PB:0]   trial;
  logic [PB:0]   diff;
  logic          ge;
  logic [CB-1:0] neg_mag;

  assign mag   = (end_price < start_price) ? start_price - end_price : end_price - start_price;
  assign trial = {rem, feed};
  assign ge    = trial >= {1'b0, dvsr};
  assign diff  = trial - {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == zdls_pkg::CNT_BITS'(CB - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvsr <= start_price;
      neg  <= end_price < start_price;
      rem  <= mag >> 1;
      sat  <= (mag >> 1) >= start_price;
      zero <= start_price == '0;
      feed <= mag[0];
      quo  <= '0;
      cnt  <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[PB-1:0] : trial[PB-1:0];
      quo  <= {quo[CB-2:0], ge};
      feed <= 1'b0;
      cnt  <= cnt + 1'b1;
    end
  end

  assign neg_mag = (sat || quo > zdls_pkg::CHG_NEG_MAG) ? zdls_pkg::CHG_NEG_MAG : quo;

  always_comb begin
    priority if (zero) begin
      change = '0;
    end else if (neg) begin
      change = $signed(CB'(0) - neg_mag);
    end else if (sat || quo[CB-1]) begin
      change = $signed(zdls_pkg::CHG_POS_MAX);
    end else begin
      change = $signed(quo);
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### rtl/zigzag_down_leg_segmenter_unit.sv
// A new sample is taken only when idle; it passes the multiply and evaluate steps, and
// a leg-closing sample then waits in the divide step for the result and a free output.
// The leg change comes from a single shift-subtract divider, one bit a cycle.
// A finished leg waits in the output register while the next sample is taken.
// Reset (synchronous, rst high): idle, direction down, all tracking state zero,
// threshold 3277.
`timescale 1ns / 1ps

module zigzag_down_leg_segmenter_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  zdls_pkg::zdls_in_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output zdls_pkg::zdls_out_t              out_item,
  input  logic                             cfg_wr_en,
  input  logic [zdls_pkg::THR_BITS-1:0]    cfg_wr_data
);

  localparam int PB = zdls_pkg::PRICE_BITS;
  localparam int OB = zdls_pkg::OFFSET_BITS;
  localparam int TB = zdls_pkg::THR_BITS;

  zdls_pkg::zdls_state_t state, state_next;

  logic [TB-1:0]    thr;
  logic [PB-1:0]    s_price;
  logic             s_first;
  logic             s_last;
  logic [PB+TB-1:0] prod;

  logic          going_up, going_up_next;
  logic [PB-1:0] ext_price, ext_price_next;
  logic [OB-1:0] ext_off, ext_off_next;
  logic [OB-1:0] piv_off, piv_off_next;
  logic [PB-1:0] piv_price, piv_price_next;
  logic [OB-1:0] sample_off, sample_off_next;
  logic          active, active_next;

  logic [OB-1:0] leg_s_off, leg_s_off_next;
  logic [OB-1:0] leg_e_off, leg_e_off_next;
  logic [PB-1:0] leg_s_prc, leg_s_prc_next;
  logic [PB-1:0] leg_e_prc, leg_e_prc_next;
  logic          leg_fin, leg_fin_next;

  logic                 out_valid_next;
  zdls_pkg::zdls_out_t  out_item_next;

  logic                             div_start;
  zdls_pkg::zdls_div_stat_t         div_st;
  logic signed [zdls_pkg::CHG_BITS-1:0] div_change;

  logic [OB-1:0] off;
  logic [PB-1:0] diff;
  logic          conf;
  logic          leg;

  assign in_ready = (state == zdls_pkg::ST_IDLE);
  assign off      = sample_off + 1'b1;
  assign diff     = going_up ? ext_price - s_price : s_price - ext_price;
  assign conf     = (ext_price != '0) && ({diff, {TB{1'b0}}} >= prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= zdls_pkg::ST_IDLE;
      thr        <= zdls_pkg::THR_RESET;
      going_up   <= 1'b0;
      ext_price  <= '0;
      ext_off    <= '0;
      piv_off    <= '0;
      piv_price  <= '0;
      sample_off <= '0;
      active     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      going_up   <= going_up_next;
      ext_price  <= ext_price_next;
      ext_off    <= ext_off_next;
      piv_off    <= piv_off_next;
      piv_price  <= piv_price_next;
      sample_off <= sample_off_next;
      active     <= active_next;
      out_valid  <= out_valid_next;
      if (cfg_wr_en) begin
        thr <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_price <= in_item.price;
      s_first <= in_item.is_first;
      s_last  <= in_item.is_last;
    end
    if (state == zdls_pkg::ST_MUL) begin
      prod <= thr * ext_price;
    end
    leg_s_off <= leg_s_off_next;
    leg_e_off <= leg_e_off_next;
    leg_s_prc <= leg_s_prc_next;
    leg_e_prc <= leg_e_prc_next;
    leg_fin   <= leg_fin_next;
    out_item  <= out_item_next;
  end

  always_comb begin
    state_next      = state;
    going_up_next   = going_up;
    ext_price_next  = ext_price;
    ext_off_next    = ext_off;
    piv_off_next    = piv_off;
    piv_price_next  = piv_price;
    sample_off_next = sample_off;
    active_next     = active;
    leg_s_off_next  = leg_s_off;
    leg_e_off_next  = leg_e_off;
    leg_s_prc_next  = leg_s_prc;
    leg_e_prc_next  = leg_e_prc;
    leg_fin_next    = leg_fin;
    out_valid_next  = out_valid && !out_ready;
    out_item_next   = out_item;
    div_start       = 1'b0;
    leg             = 1'b0;

    unique case (state)
      zdls_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = zdls_pkg::ST_MUL;
        end
      end
      zdls_pkg::ST_MUL: begin
        state_next = zdls_pkg::ST_EVAL;
      end
      zdls_pkg::ST_EVAL: begin
        if (s_first) begin
          going_up_next   = 1'b0;
          ext_price_next  = s_price;
          ext_off_next    = '0;
          piv_off_next    = '0;
          piv_price_next  = s_price;
          sample_off_next = '0;
          active_next     = !s_last;
        end else if (active) begin
          sample_off_next = off;
          if (!going_up) begin
            if (s_price < ext_price) begin
              ext_price_next = s_price;
              ext_off_next   = off;
            end else if (conf) begin
              leg            = 1'b1;
              leg_s_off_next = piv_off;
              leg_e_off_next = ext_off;
              leg_s_prc_next = piv_price;
              leg_e_prc_next = ext_price;
              leg_fin_next   = 1'b0;
              piv_off_next   = ext_off;
              piv_price_next = ext_price;
              going_up_next  = 1'b1;
              ext_price_next = s_price;
              ext_off_next   = off;
            end
          end else begin
            if (s_price > ext_price) begin
              ext_price_next = s_price;
              ext_off_next   = off;
            end else if (conf) begin
              piv_off_next   = ext_off;
              piv_price_next = ext_price;
              going_up_next  = 1'b0;
              ext_price_next = s_price;
              ext_off_next   = off;
            end
          end
          if (s_last) begin
            // closing leg that ends at the last sample
            if (!going_up_next && off > piv_off_next && !leg) begin
              leg            = 1'b1;
              leg_s_off_next = piv_off_next;
              leg_e_off_next = off;
              leg_s_prc_next = piv_price_next;
              leg_e_prc_next = s_price;
              leg_fin_next   = 1'b1;
            end
            active_next = 1'b0;
          end
        end
        div_start  = leg;
        state_next = leg ? zdls_pkg::ST_DIV : zdls_pkg::ST_IDLE;
      end
      zdls_pkg::ST_DIV: begin
        if (div_st.done && (!out_valid || out_ready)) begin
          out_valid_next                = 1'b1;
          out_item_next.leg_start_index = leg_s_off;
          out_item_next.leg_end_index   = leg_e_off;
          out_item_next.leg_start_price = leg_s_prc;
          out_item_next.leg_end_price   = leg_e_prc;
          out_item_next.leg_change      = div_change;
          out_item_next.is_final        = leg_fin;
          state_next                    = zdls_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = zdls_pkg::ST_IDLE;
      end
    endcase
  end

  zdls_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (div_start),
    .start_price (leg_s_prc_next),
    .end_price   (leg_e_prc_next),
    .stat        (div_st),
    .change      (div_change)
  );

  a_accept_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> state == zdls_pkg::ST_MUL)
    else $error("accepted item did not enter the multiply step");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divider started while busy");

  a_out_from_div: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == zdls_pkg::ST_DIV && div_st.done))
    else $error("result loaded without a finished division");

  a_last_closes: assert property (@(posedge clk) disable iff (rst)
    (state == zdls_pkg::ST_EVAL && s_last) |=> !active)
    else $error("segment still active after trough sample");

endmodule

### bench/zigzag_down_leg_segmenter_unit_test.sv
`timescale 1ns / 1ps

module zigzag_down_leg_segmenter_unit_test;

  class leg_scoreboard;
    logic [zdls_pkg::THR_BITS-1:0]    threshold;
    bit                               rising;
    bit                               in_segment;
    logic [zdls_pkg::PRICE_BITS-1:0]  ext_price;
    logic [zdls_pkg::PRICE_BITS-1:0]  pivot_price;
    logic [zdls_pkg::OFFSET_BITS-1:0] ext_off;
    logic [zdls_pkg::OFFSET_BITS-1:0] pivot_off;
    logic [zdls_pkg::OFFSET_BITS-1:0] pos;
    zdls_pkg::zdls_out_t              legs_due[$];
    int                               errors;

    function new();
      threshold = zdls_pkg::THR_RESET;
      rising = 1'b0;
      in_segment = 1'b0;
      ext_price = '0;
      pivot_price = '0;
      ext_off = '0;
      pivot_off = '0;
      pos = '0;
      errors = 0;
    endfunction

    function void set_threshold(logic [zdls_pkg::THR_BITS-1:0] v);
      threshold = v;
    endfunction

    function bit idle();
      return legs_due.size() == 0;
    endfunction

    function bit swing_met(logic [zdls_pkg::PRICE_BITS-1:0] hi,
                           logic [zdls_pkg::PRICE_BITS-1:0] lo,
                           logic [zdls_pkg::PRICE_BITS-1:0] basis);
      logic [63:0] lhs;
      logic [63:0] rhs;
      lhs = (64'(hi) - 64'(lo)) << 16;
      rhs = 64'(threshold) * 64'(basis);
      return (basis != '0) && (lhs >= rhs);
    endfunction

    // (end-start)/start in Q1.15, truncated toward zero, saturated
    function logic signed [zdls_pkg::CHG_BITS-1:0] change_q15(
        logic [zdls_pkg::PRICE_BITS-1:0] s, logic [zdls_pkg::PRICE_BITS-1:0] e);
      logic [63:0] q;
      if (s == '0) return '0;
      if (e >= s) begin
        q = ((64'(e) - 64'(s)) << 15) / 64'(s);
        if (q > 64'd32767) q = 64'd32767;
        return zdls_pkg::CHG_BITS'(q);
      end
      q = ((64'(s) - 64'(e)) << 15) / 64'(s);
      if (q > 64'd32768) q = 64'd32768;
      return zdls_pkg::CHG_BITS'(-q);
    endfunction

    function zdls_pkg::zdls_out_t build_expected(
        logic [zdls_pkg::OFFSET_BITS-1:0] s_off, logic [zdls_pkg::OFFSET_BITS-1:0] e_off,
        logic [zdls_pkg::PRICE_BITS-1:0] s_prc, logic [zdls_pkg::PRICE_BITS-1:0] e_prc,
        logic fin);
      zdls_pkg::zdls_out_t leg;
      leg.leg_start_index = s_off;
      leg.leg_end_index = e_off;
      leg.leg_start_price = s_prc;
      leg.leg_end_price = e_prc;
      leg.leg_change = change_q15(s_prc, e_prc);
      leg.is_final = fin;
      return leg;
    endfunction

    function void note_sample(zdls_pkg::zdls_in_t it);
      logic [zdls_pkg::PRICE_BITS-1:0]  c;
      logic [zdls_pkg::OFFSET_BITS-1:0] here;
      bit                               leg_out;
      c = it.price;
      leg_out = 1'b0;
      if (it.is_first) begin
        rising = 1'b0;
        ext_price = c;
        ext_off = '0;
        pivot_off = '0;
        pivot_price = c;
        pos = '0;
        in_segment = !it.is_last;
        return;
      end
      if (!in_segment) return;
      pos = pos + 1'b1;
      here = pos;
      if (!rising) begin
        if (c < ext_price) begin
          ext_price = c;
          ext_off = here;
        end else if (swing_met(c, ext_price, ext_price)) begin
          legs_due = {legs_due,
                      build_expected(pivot_off, ext_off, pivot_price, ext_price, 1'b0)};
          leg_out = 1'b1;
          pivot_off = ext_off;
          pivot_price = ext_price;
          rising = 1'b1;
          ext_price = c;
          ext_off = here;
        end
      end else begin
        if (c > ext_price) begin
          ext_price = c;
          ext_off = here;
        end else if (swing_met(ext_price, c, ext_price)) begin
          pivot_off = ext_off;
          pivot_price = ext_price;
          rising = 1'b0;
          ext_price = c;
          ext_off = here;
        end
      end
      if (it.is_last) begin
        if (!rising && here > pivot_off && !leg_out)
          legs_due = {legs_due, build_expected(pivot_off, here, pivot_price, c, 1'b1)};
        in_segment = 1'b0;
      end
    endfunction

    function void check_leg(zdls_pkg::zdls_out_t got);
      zdls_pkg::zdls_out_t want;
      if (legs_due.size() == 0) begin
        $error("leg out with none expected: %0d..%0d", got.leg_start_index,
               got.leg_end_index);
        errors++;
        return;
      end
      want = legs_due.pop_front();
      if (got.leg_start_index !== want.leg_start_index) begin
        $error("leg_start_index: expected %0d, got %0d", want.leg_start_index,
               got.leg_start_index);
        errors++;
      end
      if (got.leg_end_index !== want.leg_end_index) begin
        $error("leg_end_index: expected %0d, got %0d", want.leg_end_index, got.leg_end_index);
        errors++;
      end
      if (got.leg_start_price !== want.leg_start_price) begin
        $error("leg_start_price: expected %0d, got %0d", want.leg_start_price,
               got.leg_start_price);
        errors++;
      end
      if (got.leg_end_price !== want.leg_end_price) begin
        $error("leg_end_price: expected %0d, got %0d", want.leg_end_price, got.leg_end_price);
        errors++;
      end
      if (got.leg_change !== want.leg_change) begin
        $error("leg_change: expected %0d, got %0d", want.leg_change, got.leg_change);
        errors++;
      end
      if (got.is_final !== want.is_final) begin
        $error("is_final: expected %0d, got %0d", want.is_final, got.is_final);
        errors++;
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  zdls_pkg::zdls_in_t            in_item;
  logic                          out_valid;
  logic                          out_ready;
  zdls_pkg::zdls_out_t           out_item;
  logic                          cfg_wr_en;
  logic [zdls_pkg::THR_BITS-1:0] cfg_wr_data;

  leg_scoreboard sb = new();
  bit            no_idle = 1'b0;
  bit            long_hold_req = 1'b0;
  int            sent_count = 0;

  zigzag_down_leg_segmenter_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [zdls_pkg::PRICE_BITS-1:0] pick_base();
    int r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom;
    if (r < 30) return 32'hFFFF_FFFF - $urandom_range(0, 100);
    return $urandom_range(100, 5_000_000);
  endfunction

  function automatic logic [zdls_pkg::PRICE_BITS-1:0] next_price(
      logic [zdls_pkg::PRICE_BITS-1:0] p);
    int          r;
    logic [63:0] d;
    r = $urandom_range(0, 99);
    if (r < 3) return $urandom;
    if (r < 6) return '0;
    if (r < 9) return p;
    d = (64'(p) >> 4) * $urandom_range(0, 6) + $urandom_range(0, 3);
    if ($urandom_range(0, 1)) begin
      if (64'(p) + d > 64'hFFFF_FFFF) return '1;
      return zdls_pkg::PRICE_BITS'(64'(p) + d);
    end
    if (d > 64'(p)) return '0;
    return zdls_pkg::PRICE_BITS'(64'(p) - d);
  endfunction

  // called and returns just after a falling edge
  task automatic send_sample(logic [zdls_pkg::PRICE_BITS-1:0] price, logic first,
                             logic last);
    zdls_pkg::zdls_in_t it;
    int                 gap;
    it.price = price;
    it.is_first = first;
    it.is_last = last;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(it);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    while (!sb.idle()) @(negedge clk);
    repeat (25) @(negedge clk);
  endtask

  task automatic write_threshold(logic [zdls_pkg::THR_BITS-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    sb.set_threshold(v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_segment(int max_len);
    logic [zdls_pkg::PRICE_BITS-1:0] p;
    int                              n;
    int                              r;
    p = pick_base();
    send_sample(p, 1'b1, 1'b0);
    n = $urandom_range(1, max_len);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        p = pick_base();
        send_sample(p, 1'b1, 1'b0);
      end else if (r < 5) begin
        send_sample(next_price(p), 1'b0, 1'b1);
        return;
      end else begin
        p = next_price(p);
        send_sample(p, 1'b0, 1'b0);
      end
    end
    send_sample(next_price(p), 1'b0, 1'b1);
  endtask

  task automatic random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_sample($urandom, 1'b0, 1'($urandom_range(0, 1)));
      sent_count--;
    end else if (r < 12) begin
      send_sample(pick_base(), 1'b1, 1'b1);
    end else begin
      random_segment(40);
    end
  endtask

  // receiver
  initial begin
    int stall;
    out_ready = 1'b0;
    stall = 0;
    @(negedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall = 400;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        stall = pick_gap();
        out_ready <= (stall == 0);
        if (stall > 0) stall--;
      end
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_leg(out_item);
  end

  initial begin
    #(200_000_000);
    $display("zigzag_down_leg_segmenter_unit_test: done, errors");
    $finish;
  end

  initial begin
    logic [zdls_pkg::THR_BITS-1:0] phase_thr [7];
    int                            target;
    rst = 1'b1;
    in_valid = 1'b0;
    in_item = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    phase_thr = '{16'd3277, 16'd0, 16'hFFFF, 16'd1, 16'd6554,
                  zdls_pkg::THR_BITS'($urandom_range(0, 65535)), 16'd32768};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed, threshold at its reset value
    send_sample(32'd400, 1'b0, 1'b1);
    send_sample(32'd12345, 1'b1, 1'b1);
    send_sample(32'd10000, 1'b1, 1'b0);
    send_sample(32'd9000, 1'b0, 1'b0);
    send_sample(32'd8000, 1'b0, 1'b0);
    send_sample(32'd8500, 1'b0, 1'b0);
    send_sample(32'd0, 1'b0, 1'b0);
    send_sample(32'd100, 1'b0, 1'b0);
    send_sample(32'd50, 1'b0, 1'b1);
    send_sample(32'd0, 1'b1, 1'b0);
    send_sample(32'd77, 1'b0, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1, 1'b0);
    send_sample(32'd1, 1'b0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_sample(32'd0, 1'b0, 1'b1);
    send_sample(32'd1000, 1'b1, 1'b0);
    send_sample(32'd0, 1'b0, 1'b0);
    send_sample(32'd5000, 1'b0, 1'b1);
    send_sample(32'd700, 1'b1, 1'b0);
    send_sample(32'd600, 1'b0, 1'b0);
    send_sample(32'd900, 1'b1, 1'b0);
    send_sample(32'd800, 1'b0, 1'b1);
    drain_and_settle();
    write_threshold('0);
    send_sample(32'd500, 1'b1, 1'b0);
    send_sample(32'd400, 1'b0, 1'b0);
    send_sample(32'd400, 1'b0, 1'b0);
    send_sample(32'd400, 1'b0, 1'b1);

    sent_count = 0;
    for (int ph = 0; ph < 7; ph++) begin
      drain_and_settle();
      write_threshold(phase_thr[ph]);
      no_idle = (ph == 3);
      if (ph == 0) begin
        // output held off while a leg-rich zigzag keeps arriving
        long_hold_req = 1'b1;
        send_sample(32'd1000, 1'b1, 1'b0);
        for (int i = 0; i < 60; i++)
          send_sample(i[0] ? 32'd1000 : 32'd1300, 1'b0, 1'b0);
        send_sample(32'd900, 1'b0, 1'b1);
      end
      target = sent_count + 200;
      while (sent_count < target) random_item();
    end
    no_idle = 1'b0;

    drain_and_settle();
    repeat (20) @(negedge clk);
    if (sb.errors == 0 && sb.idle()) begin
      $display("zigzag_down_leg_segmenter_unit_test: done, clean");
    end else begin
      $display("zigzag_down_leg_segmenter_unit_test: done, errors");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/zdls_pkg.sv
rtl/zdls_div.sv
rtl/zigzag_down_leg_segmenter_unit.sv
bench/zigzag_down_leg_segmenter_unit_test.sv
